// ----- hw/rtl/lcs_pkg.sv -----
// Package for the Life stencil stream unit: result and stage-flag structs,
// rule masks and output queue depth. No dependencies.
package lcs_pkg;

  // Indexed by live neighbor count: a dead cell is born, a live cell dies.
  localparam logic [8:0] BIRTH_MASK = 9'b0_0000_1000;
  localparam logic [8:0] DEATH_MASK = 9'b1_1111_0011;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic next_alive;
    logic cell_changed;
    logic any_change;
    logic last;
  } res_t;

  // Position-derived flags for a transaction in the window stage
  typedef struct packed {
    logic emit;     // not first row, not first column
    logic border;   // emitted cell lies on top or left border
    logic two;      // last column: right border cell of row above follows
    logic lastrow;  // input is on the final row
    logic gen_end;  // final cell of the generation
  } stg_flags_t;

endpackage

// ----- hw/rtl/life_cell_stencil_stream_unit.sv -----
// Life (B3/S23) stencil over a raster cell stream: one generation per grid.
// Line stores in a 2-bit-wide lcs_ram, window in lcs_window, results in
// lcs_out_queue. Depends on lcs_pkg, lcs_ram, lcs_window, lcs_out_queue.
//
// Usage:
//  - in_valid/in_ready/in_cell_alive: one cell per transaction, raster order.
//  - out_*: one result per transaction, next state of the cell one row and
//    one column behind the input. Row 0 and column 0 give nothing; the last
//    column gives two (the second is the right border cell of the row above).
//    Border cells pass through; any_change is the sticky change flag; last
//    marks the result for row N-2, column N-1. Row N-1 is not emitted.
//  - cfg_valid/cfg_grid_size: sets side N (clamped to 3..MAX_SIDE) and
//    restarts the generation; write only while idle. cfg_ready is always high.
// Throughput: one cell per cycle. The line store is read when a cell is taken
// and written back as the cell leaves the window stage, so consecutive cells
// touch different columns and need no interlock. A cell is registered in the
// window stage, its results in lcs_out_queue. When the receiver stalls, once
// three results wait the cell in the window stage holds and in_ready drops;
// at most four results are held. Reset: N = min(1024, MAX_SIDE), position
// and change flag cleared; line store contents are not cleared.
module life_cell_stencil_stream_unit #(
  parameter int MAX_SIDE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cell_alive,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_next_alive,
  output logic        out_cell_changed,
  output logic        out_any_change,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_grid_size
);

  localparam int CW       = $clog2(MAX_SIDE);
  localparam int SW       = $clog2(MAX_SIDE + 1);
  localparam int GW       = (SW > 11) ? SW : 11;
  localparam int RST_SIDE = (MAX_SIDE < 1024) ? MAX_SIDE : 1024;

  logic          in_fire, cfg_fire, s1_adv, q_room;
  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt, last_idx_r, last_idx_nxt;
  logic [GW-1:0] g_ext;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_cell_r;
  logic [CW-1:0] s1_col_r;
  lcs_pkg::stg_flags_t s1_flags_r, flags_in;
  logic [1:0]    ram_rdata;
  logic          res0_vld, res1_vld;
  lcs_pkg::res_t res0, res1, q_res;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s1_adv    = s1_valid_r && q_room;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_valid && in_ready;

  // side clamp, kept as last index N-1
  assign g_ext = GW'(cfg_grid_size);
  always_comb begin
    if (g_ext < GW'(3)) begin
      last_idx_nxt = CW'(2);
    end else if (g_ext > GW'(MAX_SIDE)) begin
      last_idx_nxt = CW'(MAX_SIDE - 1);
    end else begin
      last_idx_nxt = CW'(g_ext - GW'(1));
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_r == last_idx_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_idx_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_comb begin
    flags_in.emit    = (row_r != '0) && (col_r != '0);
    flags_in.border  = (row_r == CW'(1)) || (col_r == CW'(1));
    flags_in.two     = (col_r == last_idx_r);
    flags_in.lastrow = (row_r == last_idx_r);
    flags_in.gen_end = (row_r == last_idx_r) && (col_r == last_idx_r);
  end

  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_idx_r <= CW'(RST_SIDE - 1);
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        last_idx_r <= last_idx_nxt;
        col_r      <= '0;
        row_r      <= '0;
      end else begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cell_r  <= in_cell_alive;
      s1_col_r   <= col_r;
      s1_flags_r <= flags_in;
    end
  end

  // bit 1: two rows above, bit 0: row above
  lcs_ram #(
    .WIDTH (2),
    .DEPTH (MAX_SIDE)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata ({ram_rdata[0], s1_cell_r}),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  lcs_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cfg_fire),
    .adv      (s1_adv),
    .flags    (s1_flags_r),
    .cell_in  (s1_cell_r),
    .top_in   (ram_rdata[1]),
    .mid_in   (ram_rdata[0]),
    .res0_vld (res0_vld),
    .res1_vld (res1_vld),
    .res0     (res0),
    .res1     (res1)
  );

  lcs_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0_vld),
    .push1     (res1_vld),
    .d0        (res0),
    .d1        (res1),
    .room      (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (q_res)
  );

  assign out_next_alive   = q_res.next_alive;
  assign out_cell_changed = q_res.cell_changed;
  assign out_any_change   = q_res.any_change;
  assign out_last         = q_res.last;

  a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r) else $error("top: accepted cell lost");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_col_r)))
    else $error("top: stalled stage changed");
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_fire && (col_r != last_idx_r)) |=>
    (col_r == CW'($past(col_r) + 1'b1)))
    else $error("top: column counter skipped");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= last_idx_r) && (row_r <= last_idx_r))
    else $error("top: position beyond grid side");

endmodule

// ----- hw/rtl/lcs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module lcs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/lcs_window.sv -----
// 3x3 window, B3/S23 rule and sticky change flag.
// Depends on lcs_pkg.
module lcs_window (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  logic               adv,
  input  lcs_pkg::stg_flags_t flags,
  input  logic               cell_in,
  input  logic               top_in,
  input  logic               mid_in,
  output logic               res0_vld,
  output logic               res1_vld,
  output lcs_pkg::res_t      res0,
  output lcs_pkg::res_t      res1
);

  logic [8:0] window_r, window_nxt;
  logic       seen_r, seen_nxt;
  logic [3:0] nb;
  logic       alive, nxt, chg, seen_upd;

  // bit k*3+r: column k (0 oldest), row r (0 top)
  assign window_nxt = {cell_in, mid_in, top_in, window_r[8:3]};
  assign alive = window_nxt[4];

  always_comb begin
    nb = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        nb = nb + 4'(window_nxt[i]);
      end
    end
  end

  always_comb begin
    if (flags.border) begin
      nxt = alive;
      chg = 1'b0;
    end else begin
      nxt = alive ? !lcs_pkg::DEATH_MASK[nb] : lcs_pkg::BIRTH_MASK[nb];
      chg = nxt ^ alive;
    end
  end

  assign seen_upd = seen_r | chg;

  always_comb begin
    res0.next_alive   = nxt;
    res0.cell_changed = chg;
    res0.any_change   = seen_upd;
    res0.last         = 1'b0;
    res1.next_alive   = window_nxt[7];
    res1.cell_changed = 1'b0;
    res1.any_change   = seen_upd;
    res1.last         = flags.lastrow;
  end

  assign res0_vld = adv && flags.emit;
  assign res1_vld = adv && flags.emit && flags.two;

  always_comb begin
    seen_nxt = seen_r;
    if (adv) begin
      if (flags.gen_end) begin
        seen_nxt = 1'b0;
      end else if (flags.emit) begin
        seen_nxt = seen_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      window_r <= '0;
      seen_r   <= 1'b0;
    end else begin
      if (adv) begin
        window_r <= window_nxt;
      end
      seen_r <= seen_nxt;
    end
  end

  // second result of a row only ever rides with the first
  a_res1_with_res0: assert property (@(posedge clk) disable iff (!rst_n)
    res1_vld |-> res0_vld) else $error("lcs_window: lone second result");
  // flag is cleared after the last cell of a generation
  a_seen_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && flags.gen_end && !clear) |=> !seen_r)
    else $error("lcs_window: change flag not cleared at generation end");
  // a border cell never reports a change
  a_border_nochg: assert property (@(posedge clk) disable iff (!rst_n)
    (res0_vld && flags.border) |-> !res0.cell_changed)
    else $error("lcs_window: border cell flagged as changed");

endmodule

// ----- hw/rtl/lcs_out_queue.sv -----
// Four-entry result queue, takes up to two results per cycle, gives one.
// Depends on lcs_pkg.
module lcs_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push0,
  input  logic          push1,
  input  lcs_pkg::res_t d0,
  input  lcs_pkg::res_t d1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output lcs_pkg::res_t out_res
);

  lcs_pkg::res_t         mem_r [lcs_pkg::QDEPTH];
  logic [lcs_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [lcs_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic                    pop;
  logic [lcs_pkg::QAW-1:0] wr_ptr_p1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= (lcs_pkg::QAW+1)'(lcs_pkg::QDEPTH - 2));
  assign out_res   = mem_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + lcs_pkg::QAW'(push0) + lcs_pkg::QAW'(push0 && push1);
    rd_ptr_nxt = rd_ptr_r + lcs_pkg::QAW'(pop);
    cnt_nxt    = cnt_r + (lcs_pkg::QAW+1)'(push0) + (lcs_pkg::QAW+1)'(push0 && push1)
               - (lcs_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= d0;
    end
    if (push0 && push1) begin
      mem_r[wr_ptr_p1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push0 |-> room) else $error("lcs_out_queue: push without room");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (lcs_pkg::QAW+1)'(lcs_pkg::QDEPTH))
    else $error("lcs_out_queue: count above depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != (lcs_pkg::QAW+1)'(lcs_pkg::QDEPTH)) |->
    (lcs_pkg::QAW'(wr_ptr_r - rd_ptr_r) == cnt_r[lcs_pkg::QAW-1:0]))
    else $error("lcs_out_queue: pointers disagree with count");

endmodule
